// ----- rtl/agc_gain_clip_top_assert.svh -----
// assertion macros for the gain control block
// used by agc_gain_clip_top only, needs a clk and rst_n in scope
`ifndef AGC_GAIN_CLIP_TOP_ASSERT_SVH
`define AGC_GAIN_CLIP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define AGC_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define AGC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define AGC_ASSERT_HOLD(lbl, cond, msg)
`define AGC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/agc_pkg.sv -----
// shared types and constants of the gain control block
// no dependencies; used by agc_div and agc_gain_clip_top
package agc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 22;
    localparam int QMAG_W   = 21;
    localparam int SCALE_W  = 32;
    localparam int FACTOR_W = 26;
    localparam int PROD_W   = SCALE_W + FACTOR_W;
    localparam int DIV_CNT_W = 6;

    localparam logic [QMAG_W-1:0]  ONE_Q20   = 21'h100000;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 32'hFFFF_FFFF;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 26'h100_0000;

    // quotient bits per division
    localparam logic [DIV_CNT_W-1:0] QDIV_STEPS = 6'd21;
    localparam logic [DIV_CNT_W-1:0] RDIV_STEPS = 6'd32;

    // register indexes
    localparam logic [1:0] REG_INIT_SCALE = 2'd0;
    localparam logic [1:0] REG_ATTACK     = 2'd1;
    localparam logic [1:0] REG_RELEASE    = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [DIV_CNT_W-1:0]  steps;
        logic [SCALE_W-1:0]    rem_init;
        logic [SCALE_W-1:0]    low;
        logic [SCALE_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [SCALE_W-1:0]    quot;
    } div_rsp_t;

endpackage

// ----- rtl/agc_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on agc_pkg for the request and response structs
module agc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  agc_pkg::div_req_t req,
    output agc_pkg::div_rsp_t rsp
);
    import agc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SCALE_W-1:0]   rem_reg, rem_next;
    logic [SCALE_W-1:0]   q_reg, q_next;
    logic [SCALE_W-1:0]   div_reg, div_next;
    logic [SCALE_W:0]     rem_shift;
    logic                 fits;

    // partial remainder always stays below the divisor
    assign rem_shift = {rem_reg, q_reg[SCALE_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            q_next    = req.low;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? SCALE_W'(rem_shift - {1'b0, div_reg}) : rem_shift[SCALE_W-1:0];
            q_next   = {q_reg[SCALE_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

// ----- rtl/agc_gain_clip_top.sv -----
// automatic gain control with output clipping, top level
// depends on agc_pkg, agc_div and agc_gain_clip_top_assert.svh
//
// usage
//   s_* stream carries one signed q4.20 sample per word in s_tdata
//   m_* stream returns the scaled sample (q2.20, 22 bits) and a clip flag
//   apb port holds initial_scale (0x0), attack_factor (0x4), release_factor (0x8)
//   writing initial_scale also loads the running gain scale (zero loads one lsb)
// timing
//   one word is in flight at a time; s_tready is high only while idle
//   m_tvalid rises in the same cycle that the block can take the next word; per word,
//   acceptance to acceptance runs update and attack when clipped (scale rising),
//   else the sample division (21 steps) and attack, or the sample division and a
//   saturated release, or both divisions (release: 32 steps) on the shared one-bit divider
//   attack uses a single registered 32x26 multiply plus a saturation state
// reset
//   registers return to 1.0 (q8.24 scale, q2.24 factors), gain scale to 1.0, output stream empty
// stalls
//   the result sits in an output register; the next word is accepted while it
//   waits, and the sequencer holds its finished result until the register frees
module agc_gain_clip_top (
    input  logic        clk,
    input  logic        rst_n,
    // sample in: [23:0] sample_in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // result out: [21:0] sample_out, [23:22] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // result flag: [0] clipped
    output logic        m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import agc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_QDIV = 6'b000010,
        S_UPD  = 6'b000100,
        S_MSAT = 6'b001000,
        S_RDIV = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [SCALE_W-1:0]   init_reg, init_next;
    logic [FACTOR_W-1:0]  attack_reg, attack_next;
    logic [FACTOR_W-1:0]  release_reg, release_next;
    logic [SCALE_W-1:0]   gain_reg, gain_next;
    logic                 ovalid_reg, ovalid_next;

    // per-word payload
    logic                 neg_reg, neg_next;
    logic                 clip_reg, clip_next;
    logic                 high_reg, high_next;
    logic [QMAG_W-1:0]    qmag_reg, qmag_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [OUT_W-1:0]     odata_reg, odata_next;
    logic                 oclip_reg, oclip_next;

    logic                 in_neg;
    logic [SAMPLE_W-1:0]  in_mag;
    logic                 in_clip;
    logic                 in_high;
    logic [PROD_W-1:0]    prod;
    logic [SCALE_W+1:0]   prod_hi;
    logic [OUT_W-1:0]     qmag_ext;
    logic                 cfg_wr;
    logic                 out_free;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    agc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // magnitude of the incoming sample; most negative code stays 2^23
    assign in_neg  = s_tdata[SAMPLE_W-1];
    assign in_mag  = in_neg ? (~s_tdata + 1'b1) : s_tdata;
    // exact level tests against the current scale
    assign in_clip = {4'b0, in_mag, 4'b0} > gain_reg;
    assign in_high = {3'b0, in_mag, 5'b0} > gain_reg;

    assign prod     = gain_reg * attack_reg;
    assign prod_hi  = prod_reg[PROD_W-1:FACTOR_W-2];
    assign qmag_ext = {1'b0, qmag_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !ovalid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        init_next    = init_reg;
        attack_next  = attack_reg;
        release_next = release_reg;
        gain_next    = gain_reg;
        ovalid_next  = ovalid_reg;
        neg_next     = neg_reg;
        clip_next    = clip_reg;
        high_next    = high_reg;
        qmag_next    = qmag_reg;
        prod_next    = prod_reg;
        odata_next   = odata_reg;
        oclip_next   = oclip_reg;
        div_req      = '0;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next  = in_neg;
                    clip_next = in_clip;
                    high_next = in_high;
                    if (in_clip)
                    begin
                        qmag_next  = ONE_Q20;
                        state_next = S_UPD;
                    end
                    else
                    begin
                        // quotient below 2^21, so the top of the dividend seeds the remainder
                        div_req.start    = 1'b1;
                        div_req.steps    = QDIV_STEPS;
                        div_req.rem_init = {5'b0, in_mag, 3'b0};
                        div_req.low      = '0;
                        div_req.divisor  = gain_reg;
                        state_next       = S_QDIV;
                    end
                end
            end
            S_QDIV:
            begin
                if (div_rsp.done)
                begin
                    qmag_next  = (div_rsp.quot[QMAG_W-1:0] > ONE_Q20) ? ONE_Q20
                                                                       : div_rsp.quot[QMAG_W-1:0];
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (high_reg)
                begin
                    prod_next  = prod;
                    state_next = S_MSAT;
                end
                else if ({2'b0, gain_reg[SCALE_W-1:8]} >= release_reg)
                begin
                    // quotient would reach 2^32 or the factor is zero
                    gain_next  = SCALE_MAX;
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = RDIV_STEPS;
                    div_req.rem_init = {8'b0, gain_reg[SCALE_W-1:8]};
                    div_req.low      = {gain_reg[7:0], 24'b0};
                    div_req.divisor  = {6'b0, release_reg};
                    state_next       = S_RDIV;
                end
            end
            S_MSAT:
            begin
                if (prod_hi[SCALE_W+1:SCALE_W] != 2'b0)
                begin
                    gain_next = SCALE_MAX;
                end
                else if (prod_hi[SCALE_W-1:0] == '0)
                begin
                    gain_next = SCALE_W'(1);
                end
                else
                begin
                    gain_next = prod_hi[SCALE_W-1:0];
                end
                state_next = S_DONE;
            end
            S_RDIV:
            begin
                if (div_rsp.done)
                begin
                    gain_next  = (div_rsp.quot == '0) ? SCALE_W'(1) : div_rsp.quot;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    odata_next  = neg_reg ? (OUT_W'(0) - qmag_ext) : qmag_ext;
                    oclip_next  = clip_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes are to arrive only while idle; the user must keep to this, the block does not enforce it
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_INIT_SCALE:
                begin
                    init_next = pwdata;
                    gain_next = (pwdata == '0) ? SCALE_W'(1) : pwdata;
                end
                REG_ATTACK:
                begin
                    attack_next = pwdata[FACTOR_W-1:0];
                end
                REG_RELEASE:
                begin
                    release_next = pwdata[FACTOR_W-1:0];
                end
                default:
                begin
                    init_next = init_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INIT_SCALE: prdata = init_reg;
            REG_ATTACK:     prdata = {6'b0, attack_reg};
            REG_RELEASE:    prdata = {6'b0, release_reg};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            init_reg    <= SCALE_ONE;
            attack_reg  <= FACTOR_ONE;
            release_reg <= FACTOR_ONE;
            gain_reg    <= SCALE_ONE;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            attack_reg  <= attack_next;
            release_reg <= release_next;
            gain_reg    <= gain_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        clip_reg  <= clip_next;
        high_reg  <= high_next;
        qmag_reg  <= qmag_next;
        prod_reg  <= prod_next;
        odata_reg <= odata_next;
        oclip_reg <= oclip_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b0, odata_reg};
    assign m_tuser  = oclip_reg;

`include "agc_gain_clip_top_assert.svh"

    // the scale is a divisor and must never reach zero
    `AGC_ASSERT_HOLD(a_gain_nonzero, gain_reg != '0, "gain scale is zero")
    // the divider never runs while a new word can enter
    `AGC_ASSERT_IMPL(a_idle_div, s_tready, !div_rsp.busy, "divider busy while idle")
    // a divider result shows up only where the sequencer waits for it
    `AGC_ASSERT_IMPL(a_div_done, div_rsp.done, state_reg == S_QDIV || state_reg == S_RDIV, "stray divider result")
    // a clipped word carries exactly plus or minus one
    `AGC_ASSERT_IMPL(a_clip_value, m_tvalid && m_tuser, m_tdata[21:0] == 22'h100000 || m_tdata[21:0] == 22'h300000, "clipped word not at full scale")

endmodule
